FILE: rtl/core/playfair_cipher_encrypt_assert.svh
// ---------------------------------------------------------------------------
// Playfair encryption assertion macros
// Clocked checks on i_clk, switched off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_CIPHER_ENCRYPT_ASSERT_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("playfair encrypt: check failed");
`define PFC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("playfair encrypt: check failed");
`else
`define PFC_ASSERT_IMP(label, ante, cons)
`define PFC_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/pfc_pkg.sv
// ---------------------------------------------------------------------------
// Playfair encryption package
// Types, codes, command and status structs, and letter helper functions.
// ---------------------------------------------------------------------------
package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;
    localparam int RC_W        = $clog2(SQUARE_SIDE);

    typedef logic [4:0]      t_letter;
    typedef logic [4:0]      t_pos;
    typedef logic [RC_W-1:0] t_rc;

    localparam t_letter LETTER_I = 5'd8;
    localparam t_letter LETTER_J = 5'd9;
    localparam t_letter LETTER_X = 5'd23;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [6:0] CIPHER_BASE  = 7'h41;

    typedef enum logic [1:0] {
        FUNC_KEY      = 2'd0,
        FUNC_KEY_DONE = 2'd1,
        FUNC_TEXT     = 2'd2,
        FUNC_END      = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_LPA,
        S_LPB,
        S_POS,
        S_SQA,
        S_SQB,
        S_OUT1,
        S_OUT2
    } t_state;

    typedef struct packed {
        logic accept;
        logic fill_step;
        logic lp_re;
        logic lp_sel_b;
        logic ld_pa;
        logic ld_pb;
        logic sq_re;
        logic sq_sel_o2;
        logic out_ld_first;
        logic out_ld_second;
    } t_cmd;

    typedef struct packed {
        logic pair_req;
        logic walk_req;
        logic fill_last;
        logic out_taken;
        logic out_valid;
    } t_sts;

    typedef struct packed {
        logic    valid;
        t_letter idx;
    } t_norm;

    // Letter index with J folded onto I; non-letters come back invalid.
    function automatic t_norm normalize(input logic [7:0] ch);
        t_norm res;
        res.valid = 1'b0;
        res.idx   = '0;
        if (ch inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            res.valid = 1'b1;
            res.idx   = t_letter'(ch - CHAR_UPPER_A);
        end else if (ch inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            res.valid = 1'b1;
            res.idx   = t_letter'(ch - CHAR_LOWER_A);
        end
        if (res.idx == LETTER_J) begin
            res.idx = LETTER_I;
        end
        return res;
    endfunction

    function automatic t_rc pos_row(input t_pos pos);
        t_rc row;
        row = '0;
        for (int r = 1; r < SQUARE_SIDE; r++) begin
            if (pos >= t_pos'(r * SQUARE_SIDE)) begin
                row = t_rc'(r);
            end
        end
        return row;
    endfunction

    function automatic t_rc pos_col(input t_pos pos);
        t_pos base;
        base = t_pos'(pos_row(pos) * SQUARE_SIDE);
        return t_rc'(pos - base);
    endfunction

    function automatic t_rc next_rc(input t_rc x);
        return (x == t_rc'(SQUARE_SIDE - 1)) ? t_rc'(0) : t_rc'(x + t_rc'(1));
    endfunction

    function automatic t_pos cell_of(input t_rc row, input t_rc col);
        return t_pos'(t_pos'(row) * t_pos'(SQUARE_SIDE) + t_pos'(col));
    endfunction

endpackage

FILE: rtl/core/pfc_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/pfc_datapath.sv
// ---------------------------------------------------------------------------
// Playfair encryption datapath
// Key square and letter position stores, pairing state, cell arithmetic and
// the output register.
// ---------------------------------------------------------------------------
module pfc_datapath
    import pfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_func,
    input  logic [7:0] i_char_in,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cipher_char,
    output logic       o_last
);

    t_func   func;
    t_norm   norm;
    logic    dbl;
    logic    pair_req;
    logic    walk_req;
    logic    key_place;
    t_letter pair_a;
    t_letter pair_b;
    logic    n_pend_v;
    t_letter n_pend;
    logic    n_prev_v;
    t_letter n_prev;

    logic    place_en;
    t_letter place_idx;
    logic    do_place;
    logic    fill_last;
    logic    out_taken;

    logic [LETTERS-1:0] r_used;
    t_pos    r_fill;
    logic    r_ready;
    logic    r_prev_v;
    t_letter r_prev;
    logic    r_pend_v;
    t_letter r_pend;
    t_letter r_k;
    t_letter r_a;
    t_letter r_b;
    t_pos    r_pa;
    t_pos    r_pb;
    logic    r_out_valid;
    logic [6:0] r_cipher;
    logic    r_last;

    t_pos    lp_rdata;
    t_letter sq_rdata;
    t_letter lp_raddr;
    t_pos    sq_raddr;
    t_rc     r1, c1, r2, c2;
    t_pos    o1, o2;

    assign func = t_func'(i_func);
    assign norm = normalize(i_char_in);
    assign dbl  = r_prev_v && (r_prev == norm.idx);

    always_comb begin
        pair_req  = 1'b0;
        walk_req  = 1'b0;
        key_place = 1'b0;
        pair_a    = r_pend;
        pair_b    = norm.idx;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_prev_v  = r_prev_v;
        n_prev    = r_prev;
        case (func)
            FUNC_KEY: begin
                key_place = !r_ready && norm.valid;
            end
            FUNC_KEY_DONE: begin
                walk_req = !r_ready;
            end
            FUNC_TEXT: begin
                if (r_ready && norm.valid) begin
                    n_prev_v = 1'b1;
                    n_prev   = norm.idx;
                    if (!r_pend_v) begin
                        // A doubled letter with nothing pending pairs the filler with it.
                        if (dbl) begin
                            pair_req = 1'b1;
                            pair_a   = LETTER_X;
                        end else begin
                            n_pend_v = 1'b1;
                            n_pend   = norm.idx;
                        end
                    end else begin
                        pair_req = 1'b1;
                        if (dbl) begin
                            pair_b   = LETTER_X;
                            n_pend   = norm.idx;
                        end else begin
                            n_pend_v = 1'b0;
                        end
                    end
                end
            end
            default: begin
                if (r_ready) begin
                    n_prev_v = 1'b0;
                    n_pend_v = 1'b0;
                    if (r_pend_v) begin
                        pair_req = 1'b1;
                        pair_b   = LETTER_X;
                    end
                end
            end
        endcase
    end

    // Key bytes place on acceptance; the key-done walk tries one letter a cycle, skipping J and used letters.
    always_comb begin
        if (i_cmd.fill_step) begin
            place_en  = (r_k != LETTER_J);
            place_idx = r_k;
        end else begin
            place_en  = i_cmd.accept && key_place;
            place_idx = norm.idx;
        end
    end

    assign do_place  = place_en && !r_used[place_idx] && (r_fill < t_pos'(CELLS));
    assign fill_last = (r_k == t_letter'(LETTERS - 1));
    assign out_taken = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_fill      <= '0;
            r_ready     <= 1'b0;
            r_prev_v    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_place) begin
                r_used[place_idx] <= 1'b1;
                r_fill            <= t_pos'(r_fill + t_pos'(1));
            end
            if (i_cmd.accept) begin
                r_prev_v <= n_prev_v;
                r_pend_v <= n_pend_v;
                if (walk_req) begin
                    r_k <= '0;
                end
            end
            if (i_cmd.fill_step) begin
                r_k <= t_letter'(r_k + t_letter'(1));
                if (fill_last) begin
                    r_ready <= 1'b1;
                end
            end
            if (i_cmd.out_ld_first || i_cmd.out_ld_second) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
            r_a    <= pair_a;
            r_b    <= pair_b;
        end
        if (i_cmd.ld_pa) begin
            r_pa <= lp_rdata;
        end
        if (i_cmd.ld_pb) begin
            r_pb <= lp_rdata;
        end
        if (i_cmd.out_ld_first) begin
            r_cipher <= 7'(CIPHER_BASE + 7'(sq_rdata));
            r_last   <= 1'b0;
        end else if (i_cmd.out_ld_second) begin
            r_cipher <= 7'(CIPHER_BASE + 7'(sq_rdata));
            r_last   <= 1'b1;
        end
    end

    assign r1 = pos_row(r_pa);
    assign c1 = pos_col(r_pa);
    assign r2 = pos_row(r_pb);
    assign c2 = pos_col(r_pb);

    always_comb begin
        if (r1 == r2) begin
            o1 = cell_of(r1, next_rc(c1));
            o2 = cell_of(r2, next_rc(c2));
        end else if (c1 == c2) begin
            o1 = cell_of(next_rc(r1), c1);
            o2 = cell_of(next_rc(r2), c2);
        end else begin
            o1 = cell_of(r1, c2);
            o2 = cell_of(r2, c1);
        end
    end

    assign lp_raddr = i_cmd.lp_sel_b ? r_b : r_a;
    assign sq_raddr = i_cmd.sq_sel_o2 ? o2 : o1;

    pfc_ram #(
        .WIDTH (5),
        .DEPTH (CELLS)
    ) u_square (
        .i_clk   (i_clk),
        .i_we    (do_place),
        .i_waddr (r_fill),
        .i_wdata (place_idx),
        .i_re    (i_cmd.sq_re),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    pfc_ram #(
        .WIDTH (5),
        .DEPTH (LETTERS)
    ) u_letter_pos (
        .i_clk   (i_clk),
        .i_we    (do_place),
        .i_waddr (place_idx),
        .i_wdata (r_fill),
        .i_re    (i_cmd.lp_re),
        .i_raddr (lp_raddr),
        .o_rdata (lp_rdata)
    );

    assign o_sts.pair_req  = pair_req;
    assign o_sts.walk_req  = walk_req;
    assign o_sts.fill_last = fill_last;
    assign o_sts.out_taken = out_taken;
    assign o_sts.out_valid = r_out_valid;

    assign o_out_valid   = r_out_valid;
    assign o_cipher_char = r_cipher;
    assign o_last        = r_last;

endmodule

FILE: rtl/core/pfc_ctrl.sv
// ---------------------------------------------------------------------------
// Playfair encryption controller
// Sequences the key-done walk, the two-step lookups and the pair output.
// ---------------------------------------------------------------------------
`include "playfair_cipher_encrypt_assert.svh"

module pfc_ctrl
    import pfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.accept = in_accept;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_sts.pair_req) begin
                        n_state = S_LPA;
                    end else if (i_sts.walk_req) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LPA: begin
                o_cmd.lp_re = 1'b1;
                n_state     = S_LPB;
            end
            S_LPB: begin
                o_cmd.lp_re    = 1'b1;
                o_cmd.lp_sel_b = 1'b1;
                o_cmd.ld_pa    = 1'b1;
                n_state        = S_POS;
            end
            S_POS: begin
                o_cmd.ld_pb = 1'b1;
                n_state     = S_SQA;
            end
            S_SQA: begin
                o_cmd.sq_re = 1'b1;
                n_state     = S_SQB;
            end
            S_SQB: begin
                // The first cipher letter is in the read register; the second is fetched now.
                o_cmd.sq_re        = 1'b1;
                o_cmd.sq_sel_o2    = 1'b1;
                o_cmd.out_ld_first = 1'b1;
                n_state            = S_OUT1;
            end
            S_OUT1: begin
                if (i_sts.out_taken) begin
                    o_cmd.out_ld_second = 1'b1;
                    n_state             = S_OUT2;
                end
            end
            S_OUT2: begin
                if (i_sts.out_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PFC_ASSERT_NXT(a_pair_starts, in_accept && i_sts.pair_req, r_state == S_LPA)
    `PFC_ASSERT_NXT(a_first_loaded, r_state == S_SQB, i_sts.out_valid)
    `PFC_ASSERT_NXT(a_pair_ends, (r_state == S_OUT2) && i_sts.out_taken, (r_state == S_IDLE) && !i_sts.out_valid)
    `PFC_ASSERT_IMP(a_out_in_window, i_sts.out_valid, (r_state == S_OUT1) || (r_state == S_OUT2))

endmodule

FILE: rtl/core/playfair_cipher_encrypt.sv
// ---------------------------------------------------------------------------
// Playfair cipher encryption
// Key bytes build the square, text bytes come out as cipher letter pairs.
// ---------------------------------------------------------------------------
// Items that emit nothing leave the controller in idle; key done walks the
// alphabet in the fill state. A pair-emitting item shows its first letter after
// the LPA, LPB, POS, SQA and SQB states, set by two position reads and two square
// reads, each store having one read port. The second letter follows in the
// cycle after the first is taken; no new item is taken until both are taken.
// Reset clears the square fill, used set, ready flag and pairing state; the
// store contents are left as they are and are rewritten by the next key.
module playfair_cipher_encrypt
    import pfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_cipher_char,
    output logic       o_last
);

    t_cmd cmd;
    t_sts sts;

    pfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pfc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_char_in     (i_char_in),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_char (o_cipher_char),
        .o_last        (o_last)
    );

endmodule

FILE: tb/playfair_cipher_encrypt_tb.sv
// ---------------------------------------------------------------------------
// Playfair cipher encryption testbench
// Builds one key square after reset, then streams text, end and key requests
// with random gaps on both channels. Every cipher letter is checked against a
// behavioural model of the square and of the letter pairing kept here.
// ---------------------------------------------------------------------------
module playfair_cipher_encrypt_tb;
    import pfc_pkg::*;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_cipher_out;

    typedef struct packed {
        t_func      f;
        logic [7:0] ch;
        logic       quiet;
    } t_row;

    localparam int TEXT_ITEMS = 600;
    localparam int TAIL_START = 520;

    // Directed opening. Rows marked quiet must produce no cipher letters.
    localparam t_row STEPS [28] = '{
        '{FUNC_TEXT,     8'h41, 1'b1},
        '{FUNC_END,      8'h00, 1'b1},
        '{FUNC_KEY,      8'h50, 1'b1},
        '{FUNC_KEY,      8'h6C, 1'b1},
        '{FUNC_KEY,      8'h00, 1'b1},
        '{FUNC_KEY,      8'h61, 1'b1},
        '{FUNC_KEY,      8'h79, 1'b1},
        '{FUNC_KEY,      8'h20, 1'b1},
        '{FUNC_KEY,      8'hFF, 1'b1},
        '{FUNC_KEY,      8'h6A, 1'b1},
        '{FUNC_KEY,      8'h5A, 1'b1},
        '{FUNC_KEY_DONE, 8'hFF, 1'b1},
        '{FUNC_KEY,      8'h51, 1'b1},
        '{FUNC_KEY_DONE, 8'h00, 1'b1},
        '{FUNC_END,      8'hFF, 1'b1},
        '{FUNC_TEXT,     8'h68, 1'b0},
        '{FUNC_TEXT,     8'h4A, 1'b0},
        '{FUNC_TEXT,     8'hFF, 1'b1},
        '{FUNC_TEXT,     8'h78, 1'b0},
        '{FUNC_TEXT,     8'h58, 1'b0},
        '{FUNC_TEXT,     8'h57, 1'b0},
        '{FUNC_TEXT,     8'h6C, 1'b0},
        '{FUNC_TEXT,     8'h67, 1'b0},
        '{FUNC_TEXT,     8'h62, 1'b0},
        '{FUNC_TEXT,     8'h62, 1'b0},
        '{FUNC_END,      8'h00, 1'b0},
        '{FUNC_END,      8'h00, 1'b1},
        '{FUNC_TEXT,     8'h00, 1'b1}
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [1:0] i_func      = 2'b00;
    logic [7:0] i_char_in   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [6:0] o_cipher_char;
    logic       o_last;

    // Model of the key square and of the pairing state.
    t_letter     sq_letter [CELLS];
    t_pos        pos_of [LETTERS];
    logic [25:0] letters_used  = '0;
    int          cells_filled  = 0;
    logic        square_done   = 1'b0;
    logic        prev_valid    = 1'b0;
    t_letter     prev_letter   = '0;
    logic        pend_valid    = 1'b0;
    t_letter     pend_letter   = '0;

    t_cipher_out cipher_q [$];

    int   err_count  = 0;
    int   n_requests = 0;
    int   n_letters  = 0;
    int   n_checked  = 0;
    logic calm       = 1'b0;
    int   ready_hold = 0;

    playfair_cipher_encrypt u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cipher_char (o_cipher_char),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Returns 1 for an ASCII letter, with J folded onto I.
    function automatic logic fold_letter(input logic [7:0] ch, output t_letter idx);
        idx = '0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            idx = t_letter'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            idx = t_letter'(ch - 8'h61);
        end else begin
            return 1'b0;
        end
        if (idx == LETTER_J) begin
            idx = LETTER_I;
        end
        return 1'b1;
    endfunction

    task automatic place_letter(input t_letter l);
        if (l == LETTER_J || letters_used[l] || cells_filled >= CELLS) begin
            return;
        end
        sq_letter[cells_filled] = l;
        pos_of[l]               = t_pos'(cells_filled);
        letters_used[l]         = 1'b1;
        cells_filled++;
    endtask

    task automatic encode_pair(input t_letter a, input t_letter b, input logic emit);
        int r1, c1, r2, c2, o1, o2;
        r1 = int'(pos_of[a]) / SQUARE_SIDE;
        c1 = int'(pos_of[a]) % SQUARE_SIDE;
        r2 = int'(pos_of[b]) / SQUARE_SIDE;
        c2 = int'(pos_of[b]) % SQUARE_SIDE;
        if (r1 == r2) begin
            o1 = r1 * SQUARE_SIDE + (c1 + 1) % SQUARE_SIDE;
            o2 = r2 * SQUARE_SIDE + (c2 + 1) % SQUARE_SIDE;
        end else if (c1 == c2) begin
            o1 = ((r1 + 1) % SQUARE_SIDE) * SQUARE_SIDE + c1;
            o2 = ((r2 + 1) % SQUARE_SIDE) * SQUARE_SIDE + c2;
        end else begin
            o1 = r1 * SQUARE_SIDE + c2;
            o2 = r2 * SQUARE_SIDE + c1;
        end
        if (emit) begin
            cipher_q.push_back('{7'(CIPHER_BASE + 7'(sq_letter[o1])), 1'b0});
            cipher_q.push_back('{7'(CIPHER_BASE + 7'(sq_letter[o2])), 1'b1});
        end
    endtask

    task automatic pair_letter(input t_letter l, input logic emit);
        if (!pend_valid) begin
            pend_letter = l;
            pend_valid  = 1'b1;
        end else begin
            encode_pair(pend_letter, l, emit);
            pend_valid = 1'b0;
        end
    endtask

    task automatic predict_cipher(input t_func f, input logic [7:0] ch, input logic emit);
        t_letter l;
        logic    is_letter;
        is_letter = fold_letter(ch, l);
        case (f)
            FUNC_KEY: begin
                if (!square_done && is_letter) begin
                    place_letter(l);
                end
            end
            FUNC_KEY_DONE: begin
                if (!square_done) begin
                    for (int k = 0; k < LETTERS; k++) begin
                        place_letter(t_letter'(k));
                    end
                    square_done = 1'b1;
                end
            end
            FUNC_TEXT: begin
                if (square_done && is_letter) begin
                    // A letter equal to the one just before it gets an X between them.
                    if (prev_valid && prev_letter == l) begin
                        pair_letter(LETTER_X, emit);
                    end
                    pair_letter(l, emit);
                    prev_letter = l;
                    prev_valid  = 1'b1;
                end
            end
            default: begin
                if (square_done) begin
                    if (pend_valid) begin
                        pair_letter(LETTER_X, emit);
                    end
                    pend_valid = 1'b0;
                    prev_valid = 1'b0;
                end
            end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic put_request(input t_func f, input logic [7:0] ch, input logic emit);
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_char_in  <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        n_requests++;
        predict_cipher(f, ch, emit);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 5) == 0) begin
            idle_sender($urandom_range(1, 19));
        end
    endtask

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(1, 19);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cipher_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_q.size() == 0) begin
                $error("unexpected cipher letter %c (last %0d)", o_cipher_char, o_last);
                err_count++;
            end else begin
                want = cipher_q.pop_front();
                n_checked++;
                if (o_cipher_char !== want.ch) begin
                    $error("cipher_char: expected %c, got %c", want.ch, o_cipher_char);
                    err_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    err_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_func      f;
        logic [7:0] ch;
        logic [7:0] last_char;
        t_letter    l;
        int         r;
        int         next_chunk;
        logic       pressure_done;
        last_char     = 8'h41;
        next_chunk    = 0;
        pressure_done = 1'b0;
        calm          = ($urandom_range(0, 1) == 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (STEPS[k]) begin
            put_request(STEPS[k].f, STEPS[k].ch, !STEPS[k].quiet);
            maybe_pause();
        end

        while (n_requests < TEXT_ITEMS) begin
            if (n_requests >= next_chunk) begin
                calm       = ($urandom_range(0, 3) == 0);
                next_chunk = next_chunk + 40;
            end
            if (n_requests >= TAIL_START) begin
                calm = 1'b1;
            end
            // Hold the sender off once until the block has drained.
            if (n_requests >= 300 && !pressure_done) begin
                idle_sender(1);
                while (cipher_q.size() != 0) @(posedge i_clk);
                pressure_done = 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 72) begin
                f = FUNC_TEXT;
            end else if (r < 82) begin
                f = FUNC_END;
            end else if (r < 91) begin
                f = FUNC_KEY;
            end else begin
                f = FUNC_KEY_DONE;
            end

            r = $urandom_range(0, 99);
            if (r < 15) begin
                ch = 8'($urandom_range(0, 255));
            end else if (r < 32) begin
                // Repeat the previous letter, sometimes in the other case.
                ch = last_char ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
            end else begin
                ch = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
            end
            if (f == FUNC_TEXT && fold_letter(ch, l)) begin
                last_char = ch;
            end

            put_request(f, ch, 1'b1);
            if (f == FUNC_END || (f == FUNC_TEXT && fold_letter(ch, l))) begin
                n_letters++;
            end
            maybe_pause();
        end

        i_in_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d requests after one key (%0d text letters and ends).",
                 n_requests, n_letters);
        $display("Compared %0d cipher letters, %0d mismatches.", n_checked, err_count);
        if (err_count == 0) begin
            $display("playfair_cipher_encrypt_tb: done, clean");
        end else begin
            $display("playfair_cipher_encrypt_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("playfair_cipher_encrypt_tb: done, errors");
        $finish;
    end

endmodule
